[hw/rtl/sct_pkg.sv]
// Shared constants, widths and the controller-to-datapath command type.
package sct_pkg;

  localparam int ANGLE_W   = 32;
  localparam int VALUE_W   = 32;
  localparam int THR_W     = 31;
  localparam int TERMS_W   = 5;
  localparam int MAX_TERMS_DEF = 16;

  localparam logic [THR_W-1:0] THR_RESET = 31'd107;

  // Angle reduction works on the magnitude in Q.56.
  localparam int RED_W     = 64;
  localparam int RED_STEPS = 5;
  localparam logic [RED_W-1:0] PI_Q56     = 64'h03243F6A8885A309;
  localparam logic [RED_W-1:0] TWO_PI_Q56 = 64'h06487ED5110B4612;

  // Series datapath widths (Q.30 magnitudes).
  localparam int X_W     = 32;
  localparam int X2_W    = 34;
  localparam int TMAG_W  = 33;
  localparam int MUL_B_W = 17;
  localparam int PP_W    = TMAG_W + MUL_B_W;
  localparam int PROD_W  = 67;
  localparam int FRAC_W  = 30;
  localparam int SUM_W   = 40;

  // Term divider: restoring, DIV_BITS quotient bits per cycle.
  localparam int NUM_W     = 40;
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = NUM_W / DIV_BITS;
  localparam int STEP_W    = 3;

  localparam logic signed [SUM_W-1:0] ONE_Q30     = 40'sd1073741824;
  localparam logic signed [SUM_W-1:0] NEG_ONE_Q30 = -40'sd1073741824;

  typedef struct packed {
    logic load_in;
    logic red_step;
    logic fold;
    logic xround;
    logic sq_mode;
    logic mul_lo;
    logic mul_hi;
    logic sq_done;
    logic d_load;
    logic div_load;
    logic div_step;
    logic term_upd;
    logic out_load;
  } dp_cmd_t;

endpackage

[hw/rtl/sct_dp.sv]
// Datapath: angle reduction, shared multiplier, term divider and series accumulator.
module sct_dp #(
  parameter int MAX_TERMS = sct_pkg::MAX_TERMS_DEF,
  parameter int CNT_W     = $clog2(MAX_TERMS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sct_pkg::THR_W-1:0]           cfg_wdata,
  input  logic                                in_func,
  input  logic signed [sct_pkg::ANGLE_W-1:0]  in_angle,
  input  sct_pkg::dp_cmd_t                    cmd,
  input  logic [CNT_W-1:0]                    term_n,
  output logic                                le_thr,
  output logic signed [sct_pkg::VALUE_W-1:0]  out_value
);
  import sct_pkg::*;

  localparam int DIV_W = $clog2(4 * MAX_TERMS * MAX_TERMS);
  localparam int NSUM_W = FRAC_W + NUM_W;

  logic [THR_W-1:0]        thr_r;
  logic                    func_r;
  logic                    neg_r;
  logic [RED_W-1:0]        red_r;
  logic [RED_W-1:0]        dvs_r;
  logic [X_W-1:0]          x_r;
  logic [X2_W-1:0]         x2_r;
  logic [PROD_W-1:0]       prod_r;
  logic [DIV_W-1:0]        d_r;
  logic [NUM_W-1:0]        num_r;
  logic [DIV_W-1:0]        rem_r;
  logic [TMAG_W-1:0]       tmag_r;
  logic                    tneg_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [VALUE_W-1:0]      out_value_r;

  logic [X_W-1:0]          mag;
  logic [RED_W:0]          x_rnd;
  logic [TMAG_W-1:0]       mul_a;
  logic [X2_W-1:0]         mul_b;
  logic [MUL_B_W-1:0]      mul_bs;
  logic [PP_W-1:0]         pp;
  logic [PROD_W-1:0]       sq_rnd;
  logic [NSUM_W-1:0]       num_sum;
  logic [CNT_W:0]          n2;
  logic [CNT_W:0]          fa;
  logic [CNT_W:0]          fb;
  logic [2*CNT_W+1:0]      dprod;
  logic [NUM_W-1:0]        div_num;
  logic [DIV_W-1:0]        div_rem;
  logic [DIV_W:0]          trial;
  logic signed [SUM_W-1:0] q_s;
  logic signed [SUM_W-1:0] x_s;
  logic signed [SUM_W-1:0] sat;

  always_comb begin
    mag    = in_angle[ANGLE_W-1] ? (~in_angle + 1'b1) : in_angle;
    x_rnd  = {1'b0, red_r} + (RED_W+1)'(1 << 25);
    mul_a  = cmd.sq_mode ? {1'b0, x_r} : tmag_r;
    mul_b  = cmd.sq_mode ? {2'b00, x_r} : x2_r;
    mul_bs = cmd.mul_hi ? mul_b[X2_W-1:MUL_B_W] : mul_b[MUL_B_W-1:0];
    pp     = PP_W'(mul_a) * PP_W'(mul_bs);
    sq_rnd = prod_r + PROD_W'(1 << 29);
    // Rounding of the product and the half-divisor bias fold into one add.
    num_sum = NSUM_W'(prod_r) + (NSUM_W'(d_r >> 1) << FRAC_W) + NSUM_W'(1 << 29);
    n2     = {term_n, 1'b0};
    fa     = func_r ? (n2 - 1'b1) : n2;
    fb     = func_r ? n2 : (n2 + 1'b1);
    dprod  = (2*CNT_W+2)'(fa) * (2*CNT_W+2)'(fb);
    q_s    = $signed(SUM_W'(num_r));
    x_s    = $signed(SUM_W'(x_r));
    le_thr = (num_r <= NUM_W'(thr_r));
  end

  // Eight restoring steps of the term division per cycle.
  always_comb begin
    div_num = num_r;
    div_rem = rem_r;
    trial   = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial   = {div_rem, div_num[NUM_W-1]};
      div_num = {div_num[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, d_r}) begin
        div_rem    = DIV_W'(trial - {1'b0, d_r});
        div_num[0] = 1'b1;
      end else begin
        div_rem = trial[DIV_W-1:0];
      end
    end
  end

  always_comb begin
    if (sum_r > ONE_Q30) begin
      sat = ONE_Q30;
    end else if (sum_r < NEG_ONE_Q30) begin
      sat = NEG_ONE_Q30;
    end else begin
      sat = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      neg_r  <= in_angle[ANGLE_W-1];
      red_r  <= {mag, 32'h0};
      dvs_r  <= TWO_PI_Q56 << (RED_STEPS - 1);
    end
    if (cmd.red_step) begin
      if (red_r >= dvs_r) begin
        red_r <= red_r - dvs_r;
      end
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.fold && (red_r > PI_Q56)) begin
      red_r <= TWO_PI_Q56 - red_r;
      neg_r <= ~neg_r;
    end
    if (cmd.xround) begin
      x_r <= x_rnd[26 +: X_W];
    end
    if (cmd.mul_lo) begin
      prod_r <= PROD_W'(pp);
    end
    if (cmd.mul_hi) begin
      prod_r <= prod_r + (PROD_W'(pp) << MUL_B_W);
    end
    if (cmd.sq_done) begin
      x2_r <= sq_rnd[FRAC_W +: X2_W];
      if (func_r) begin
        tmag_r <= TMAG_W'(1 << FRAC_W);
        tneg_r <= 1'b0;
        sum_r  <= ONE_Q30;
      end else begin
        tmag_r <= {1'b0, x_r};
        tneg_r <= neg_r;
        sum_r  <= neg_r ? -x_s : x_s;
      end
    end
    if (cmd.d_load) begin
      d_r <= dprod[DIV_W-1:0];
    end
    if (cmd.div_load) begin
      num_r <= num_sum[FRAC_W +: NUM_W];
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      num_r <= div_num;
      rem_r <= div_rem;
    end
    if (cmd.term_upd) begin
      tmag_r <= num_r[TMAG_W-1:0];
      tneg_r <= ~tneg_r;
      sum_r  <= tneg_r ? (sum_r + q_s) : (sum_r - q_s);
    end
    if (cmd.out_load) begin
      out_value_r <= sat[VALUE_W-1:0];
    end
  end

  assign out_value = $signed(out_value_r);

endmodule

[hw/rtl/sct_ctrl.sv]
// Controller: sequences reduction, squaring and the term loop, and owns the result beat.
module sct_ctrl #(
  parameter int MAX_TERMS = sct_pkg::MAX_TERMS_DEF,
  parameter int CNT_W     = $clog2(MAX_TERMS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sct_pkg::TERMS_W-1:0]  out_terms_used,
  output logic                         out_capped,
  output sct_pkg::dp_cmd_t             cmd,
  output logic [CNT_W-1:0]             term_n,
  input  logic                         le_thr
);
  import sct_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;
  localparam logic [3:0] S_FOLD  = 4'd2;
  localparam logic [3:0] S_XRND  = 4'd3;
  localparam logic [3:0] S_SQLO  = 4'd4;
  localparam logic [3:0] S_SQHI  = 4'd5;
  localparam logic [3:0] S_SQFIN = 4'd6;
  localparam logic [3:0] S_TLO   = 4'd7;
  localparam logic [3:0] S_THI   = 4'd8;
  localparam logic [3:0] S_DLOAD = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_TUPD  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               capped_r, capped_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TERMS_W-1:0] terms_r, terms_nxt;
  logic               ocap_r, ocap_nxt;
  logic [CNT_W-1:0]   cnt_inc;
  logic               out_load;

  assign cnt_inc  = cnt_r + 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    capped_nxt = capped_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          step_nxt    = '0;
          state_nxt   = S_RED;
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(RED_STEPS - 1)) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_XRND;
      end
      S_XRND: begin
        cmd.xround = 1'b1;
        state_nxt  = S_SQLO;
      end
      S_SQLO: begin
        cmd.sq_mode = 1'b1;
        cmd.mul_lo  = 1'b1;
        state_nxt   = S_SQHI;
      end
      S_SQHI: begin
        cmd.sq_mode = 1'b1;
        cmd.mul_hi  = 1'b1;
        state_nxt   = S_SQFIN;
      end
      S_SQFIN: begin
        cmd.sq_done = 1'b1;
        cnt_nxt     = CNT_W'(1);
        capped_nxt  = 1'b0;
        state_nxt   = S_TLO;
      end
      S_TLO: begin
        cmd.mul_lo = 1'b1;
        cmd.d_load = 1'b1;
        state_nxt  = S_THI;
      end
      S_THI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_TUPD;
        end
      end
      S_TUPD: begin
        cmd.term_upd = 1'b1;
        cnt_nxt      = cnt_inc;
        if (le_thr) begin
          state_nxt = S_FIN;
        end else if (cnt_inc >= CNT_W'(MAX_TERMS)) begin
          capped_nxt = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_TLO;
        end
      end
      S_FIN: begin
        if (out_load) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    terms_nxt     = terms_r;
    ocap_nxt      = ocap_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      terms_nxt     = TERMS_W'(cnt_r);
      ocap_nxt      = capped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      capped_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      capped_r    <= capped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    terms_r <= terms_nxt;
    ocap_r  <= ocap_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_terms_used = terms_r;
  assign out_capped     = ocap_r;
  assign term_n         = cnt_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RED))
    else $error("accepted beat did not start angle reduction");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (cnt_r >= CNT_W'(2) && cnt_r <= CNT_W'(MAX_TERMS)))
    else $error("term count out of range at result");

  a_cap_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && capped_r) |-> (cnt_r == CNT_W'(MAX_TERMS)))
    else $error("cap flagged below the term limit");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RED || state_r == S_DIV) |-> (step_r < STEP_W'(DIV_STEPS)))
    else $error("step counter overran");

endmodule

[hw/rtl/sine_cosine_taylor_series.sv]
// Top level of the Taylor-series sine/cosine unit.
// Usage:
//   Input beat: in_func (0 sine, 1 cosine) and in_angle (signed Q8.24 radians),
//   taken when in_valid is high and in_stall is low. One result beat follows on
//   out_value (signed Q2.30, saturated to +-1), out_terms_used and out_capped,
//   taken when out_valid is high and out_stall is low.
//   User writes stop_threshold on cfg_we/cfg_wdata only when idle; not enforced.
// Sequencing:
//   One item is worked at a time; out_terms_used counts the first term and every
//   added term. The next beat can be taken once the result is presented.
//   Each added term takes a low and a high pass on the shared 33x17 multiplier,
//   forms the rounded dividend, runs the eight-bit-per-cycle divider for five
//   steps and then accumulates. Reduction takes five compare-subtract steps.
// Reset and stall:
//   Reset returns the sequencer to idle, drops out_valid and restores the
//   threshold to 107. A result waiting under out_stall sits in the output
//   register; the next input beat is accepted meanwhile, and its result waits
//   for that register to be emptied.
module sine_cosine_taylor_series #(
  parameter int MAX_TERMS = sct_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sct_pkg::THR_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic signed [sct_pkg::ANGLE_W-1:0]  in_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sct_pkg::VALUE_W-1:0]  out_value,
  output logic [sct_pkg::TERMS_W-1:0]         out_terms_used,
  output logic                                out_capped
);
  import sct_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  dp_cmd_t          cmd;
  logic [CNT_W-1:0] term_n;
  logic             le_thr;

  sct_ctrl #(
    .MAX_TERMS (MAX_TERMS),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_terms_used (out_terms_used),
    .out_capped     (out_capped),
    .cmd            (cmd),
    .term_n         (term_n),
    .le_thr         (le_thr)
  );

  sct_dp #(
    .MAX_TERMS (MAX_TERMS),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_func   (in_func),
    .in_angle  (in_angle),
    .cmd       (cmd),
    .term_n    (term_n),
    .le_thr    (le_thr),
    .out_value (out_value)
  );

endmodule
